// ===== rtl/fcsm_pkg.sv =====
`timescale 1ns / 1ps
package fcsm_pkg;

    localparam int CHANNELS_DEF      = 4;
    localparam int FRAC_BITS_DEF     = 16;
    localparam int MEM_DEPTH_DEF     = 65536;
    localparam logic [31:0] RATE_FACTOR_RESET = 32'd10541640;

    localparam logic [1:0] FUNC_TICK  = 2'd0;
    localparam logic [1:0] FUNC_START = 2'd1;
    localparam logic [1:0] FUNC_WRITE = 2'd2;

    typedef struct packed {
        logic [15:0] start;
        logic [31:0] length;
        logic [31:0] loop_begin;
        logic [31:0] loop_finish;
        logic        wrap_en;
        logic [15:0] period;
    } chan_rec_t;

endpackage

// ===== rtl/four_channel_sample_mixer.sv =====
`timescale 1ns / 1ps
// Sample playback mixer: CHANNELS voices read 8-bit signed bytes from one
// sample memory and a tick word returns their sum divided by four, truncated
// toward zero. A tick walks the channels one after another through a
// channel-setting memory and a position memory, both with registered reads:
// a stopped channel is skipped, a channel that ends is stopped, one with
// period 0 adds its sample without a position step, and an advancing channel
// runs the 32-step radix-2 divider that forms rate_factor / period and writes
// its position back. The result register is then loaded once the output is
// free. The next word is taken while a result waits to be read. The sample
// memory is not cleared at reset.
module four_channel_sample_mixer
    import fcsm_pkg::*;
#(
    parameter int CHANNELS         = CHANNELS_DEF,
    parameter int FRAC_BITS        = FRAC_BITS_DEF
)(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [31:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         func,
    input  logic [1:0]         channel,
    input  logic [15:0]        sample_addr,
    input  logic [31:0]        length,
    input  logic [31:0]        loop_start,
    input  logic [31:0]        loop_end,
    input  logic               loop_on,
    input  logic [15:0]        period,
    input  logic signed [7:0]  sample_data,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [7:0]  mixed_sample
);

    localparam int SAMPLE_MEM_DEPTH = MEM_DEPTH_DEF;
    localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int AW = $clog2(SAMPLE_MEM_DEPTH);
    localparam int SW = 8 + $clog2(CHANNELS) + 1;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;
    localparam logic [2:0] S_CHK  = 3'd2;
    localparam logic [2:0] S_SMP  = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;
    localparam logic [2:0] S_WB   = 3'd5;
    localparam logic [2:0] S_FIN  = 3'd6;

    logic [7:0]       samp_mem [SAMPLE_MEM_DEPTH];
    chan_rec_t        chan_mem [CHANNELS];
    logic [31:0]      pos_mem  [CHANNELS];

    logic [2:0]       state_reg, state_next;
    logic [CW-1:0]    ch_reg, ch_next;
    logic [CHANNELS-1:0] playing_reg, playing_next;
    logic [31:0]      rate_reg;
    logic signed [SW-1:0] sum_reg, sum_next;
    logic [31:0]      posw_reg, posw_next;
    chan_rec_t        chan_rd_reg;
    logic [31:0]      pos_rd_reg;
    logic signed [7:0] samp_rd_reg;
    logic [16:0]      rem_reg, rem_next;
    logic [31:0]      quot_reg, quot_next;
    logic [4:0]       cnt_reg, cnt_next;
    logic             out_valid_reg;
    logic signed [7:0] out_data_reg;

    logic             accept;
    logic [CW-1:0]    in_ch;
    logic [31:0]      pos_eff;
    logic [32:0]      addr_sum;
    logic [AW-1:0]    rd_addr;
    logic             chan_rd_en, samp_rd_en, pos_wr_en;
    logic [31:0]      pos_wr_data;
    logic [16:0]      div_try;
    logic             last_ch;
    logic             out_free;
    logic signed [SW-1:0] sum_adj, quo;
    logic signed [7:0] quo_sat;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign in_ch     = CW'(channel);
    assign out_valid = out_valid_reg;
    assign mixed_sample = out_data_reg;
    assign out_free  = !out_valid_reg || out_ready;
    assign last_ch   = (ch_reg == CW'(CHANNELS - 1));

    assign pos_eff  = (chan_rd_reg.wrap_en && (pos_rd_reg > chan_rd_reg.loop_finish))
                      ? chan_rd_reg.loop_begin : pos_rd_reg;
    assign addr_sum = {17'd0, chan_rd_reg.start} + 33'(pos_eff >> FRAC_BITS);
    assign rd_addr  = addr_sum[AW-1:0];
    assign div_try  = {rem_reg[15:0], quot_reg[31]};

    assign sum_adj = (sum_reg < 0) ? sum_reg + SW'(3) : sum_reg;
    assign quo     = sum_adj >>> 2;
    assign quo_sat = (quo > SW'(127)) ? 8'sd127 :
                     (quo < -SW'(128)) ? -8'sd128 : quo[7:0];

    always_comb
    begin
        state_next   = state_reg;
        ch_next      = ch_reg;
        playing_next = playing_reg;
        sum_next     = sum_reg;
        posw_next    = posw_reg;
        rem_next     = rem_reg;
        quot_next    = quot_reg;
        cnt_next     = cnt_reg;
        chan_rd_en   = 1'b0;
        samp_rd_en   = 1'b0;
        pos_wr_en    = 1'b0;
        pos_wr_data  = pos_eff;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && func == FUNC_TICK)
                begin
                    ch_next    = '0;
                    sum_next   = '0;
                    state_next = S_RD;
                end
                else if (accept && func == FUNC_START && 32'(channel) < CHANNELS)
                begin
                    playing_next[in_ch] = 1'b1;
                end
            end
            S_RD:
            begin
                if (playing_reg[ch_reg])
                begin
                    chan_rd_en = 1'b1;
                    state_next = S_CHK;
                end
                else if (last_ch)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    ch_next = ch_reg + CW'(1);
                end
            end
            S_CHK:
            begin
                pos_wr_en = 1'b1;
                posw_next = pos_eff;
                if (pos_eff < chan_rd_reg.length)
                begin
                    samp_rd_en = 1'b1;
                    state_next = S_SMP;
                end
                else
                begin
                    playing_next[ch_reg] = 1'b0;
                    ch_next    = last_ch ? ch_reg : ch_reg + CW'(1);
                    state_next = last_ch ? S_FIN : S_RD;
                end
            end
            S_SMP:
            begin
                sum_next = sum_reg + SW'(samp_rd_reg);
                if (chan_rd_reg.period != 16'd0)
                begin
                    rem_next   = '0;
                    quot_next  = rate_reg;
                    cnt_next   = '0;
                    state_next = S_DIV;
                end
                else
                begin
                    ch_next    = last_ch ? ch_reg : ch_reg + CW'(1);
                    state_next = last_ch ? S_FIN : S_RD;
                end
            end
            S_DIV:
            begin
                if (div_try >= {1'b0, chan_rd_reg.period})
                begin
                    rem_next  = div_try - {1'b0, chan_rd_reg.period};
                    quot_next = {quot_reg[30:0], 1'b1};
                end
                else
                begin
                    rem_next  = div_try;
                    quot_next = {quot_reg[30:0], 1'b0};
                end
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd31)
                begin
                    state_next = S_WB;
                end
            end
            S_WB:
            begin
                pos_wr_en   = 1'b1;
                pos_wr_data = posw_reg + quot_reg;
                ch_next     = last_ch ? ch_reg : ch_reg + CW'(1);
                state_next  = last_ch ? S_FIN : S_RD;
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ch_reg        <= '0;
            playing_reg   <= '0;
            cnt_reg       <= '0;
            rate_reg      <= RATE_FACTOR_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            ch_reg      <= ch_next;
            playing_reg <= playing_next;
            cnt_reg     <= cnt_next;
            if (cfg_valid)
            begin
                rate_reg <= cfg_data;
            end
            if (state_reg == S_FIN && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg  <= sum_next;
        posw_reg <= posw_next;
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
        if (state_reg == S_FIN && out_free)
        begin
            out_data_reg <= quo_sat;
        end
    end

    // hold channel settings and positions
    always_ff @(posedge clk)
    begin
        if (accept && func == FUNC_START && 32'(channel) < CHANNELS)
        begin
            chan_mem[in_ch] <= '{start: sample_addr, length: length,
                                 loop_begin: loop_start, loop_finish: loop_end,
                                 wrap_en: loop_on, period: period};
            pos_mem[in_ch]  <= '0;
        end
        else if (pos_wr_en)
        begin
            pos_mem[ch_reg] <= pos_wr_data;
        end
        if (chan_rd_en)
        begin
            chan_rd_reg <= chan_mem[ch_reg];
            pos_rd_reg  <= pos_mem[ch_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && func == FUNC_WRITE)
        begin
            samp_mem[sample_addr[AW-1:0]] <= sample_data;
        end
        if (samp_rd_en)
        begin
            samp_rd_reg <= samp_mem[rd_addr];
        end
    end

`ifndef ASSERT_OFF
    a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_DIV |-> cnt_reg == 5'd0)
        else $error("divider count left running");
    a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept && func == FUNC_TICK |=> !in_ready)
        else $error("tick did not start channel walk");
    a_play_rise: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(playing_reg[0]) |-> $past(accept && func == FUNC_START))
        else $error("channel started without start word");
    a_fin_out: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_FIN && out_free |=> out_valid)
        else $error("result not presented");
`endif

endmodule

// ===== bench/tb_four_channel_sample_mixer.sv =====
`timescale 1ns / 1ps
module tb_four_channel_sample_mixer;
    import fcsm_pkg::*;

    localparam logic [1:0] FUNC_NONE = 2'd3;
    localparam int SETTLE_CYCLES = 200;
    localparam int HOLD_CYCLES = 600;

    typedef struct {
        logic [1:0]  fn;
        logic [1:0]  ch;
        logic [15:0] addr;
        logic [31:0] len;
        logic [31:0] lbeg;
        logic [31:0] lend;
        logic        lon;
        logic [15:0] per;
        logic [7:0]  data;
        bit          typed;
        logic [7:0]  want;
    } word_t;

    logic clk;
    logic rst_n;
    logic cfg_valid;
    logic cfg_ready;
    logic [31:0] cfg_data;
    logic in_valid;
    logic in_ready;
    logic [1:0] func;
    logic [1:0] channel;
    logic [15:0] sample_addr;
    logic [31:0] length;
    logic [31:0] loop_start;
    logic [31:0] loop_end;
    logic loop_on;
    logic [15:0] period;
    logic signed [7:0] sample_data;
    logic out_valid;
    logic out_ready;
    logic signed [7:0] mixed_sample;

    four_channel_sample_mixer dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .func(func), .channel(channel), .sample_addr(sample_addr),
        .length(length), .loop_start(loop_start), .loop_end(loop_end),
        .loop_on(loop_on), .period(period), .sample_data(sample_data),
        .out_valid(out_valid), .out_ready(out_ready), .mixed_sample(mixed_sample)
    );

    logic [31:0] rate;
    logic [7:0]  mem_byte [0:65535];
    bit          mem_known [0:65535];
    logic [31:0] pos [4];
    logic [15:0] base [4];
    logic [31:0] span [4];
    logic [31:0] lp_beg [4];
    logic [31:0] lp_end [4];
    logic        lp_on [4];
    logic [15:0] step_div [4];
    logic        playing [4];

    logic [7:0] mix_expected [$];
    int errors;
    bit no_gaps;
    bit hold_req;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #30ms;
        $display("FAIL");
        $finish;
    end

    function automatic int draw_gap();
        return no_gaps ? 0 : $urandom_range(0, 13);
    endfunction

    task automatic report(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    function automatic logic [15:0] read_addr(int c, logic [31:0] p);
        return base[c] + p[31:16];
    endfunction

    function automatic logic [7:0] mix_next();
        int sum;
        int q;
        sum = 0;
        for (int c = 0; c < 4; c++)
        begin
            if (!playing[c])
                continue;
            if (lp_on[c] && pos[c] > lp_end[c])
                pos[c] = lp_beg[c];
            if (pos[c] < span[c])
            begin
                sum += $signed(mem_byte[read_addr(c, pos[c])]);
                if (step_div[c] != 0)
                    pos[c] = pos[c] + rate / step_div[c];
            end
            else
                playing[c] = 1'b0;
        end
        q = sum / 4;
        if (q > 127)
            q = 127;
        if (q < -128)
            q = -128;
        return q[7:0];
    endfunction

    task automatic apply_word(word_t w);
        logic [7:0] m;
        case (w.fn)
            FUNC_TICK:
            begin
                m = mix_next();
                mix_expected.push_back(w.typed ? w.want : m);
            end
            FUNC_START:
            begin
                base[w.ch] = w.addr;
                span[w.ch] = w.len;
                lp_beg[w.ch] = w.lbeg;
                lp_end[w.ch] = w.lend;
                lp_on[w.ch] = w.lon;
                step_div[w.ch] = w.per;
                pos[w.ch] = '0;
                playing[w.ch] = 1'b1;
            end
            FUNC_WRITE:
            begin
                mem_byte[w.addr] = w.data;
                mem_known[w.addr] = 1'b1;
            end
            default: ;
        endcase
    endtask

    task automatic drive_word(word_t w);
        int g;
        g = draw_gap();
        if (g > 0)
        begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        func <= w.fn;
        channel <= w.ch;
        sample_addr <= w.addr;
        length <= w.len;
        loop_start <= w.lbeg;
        loop_end <= w.lend;
        loop_on <= w.lon;
        period <= w.per;
        sample_data <= w.data;
        in_valid <= 1'b1;
        do @(posedge clk); while (!in_ready);
    endtask

    function automatic word_t mk(logic [1:0] fn, logic [1:0] ch, logic [15:0] addr,
                                 logic [31:0] len, logic [31:0] lbeg, logic [31:0] lend,
                                 logic lon, logic [15:0] per, logic [7:0] data,
                                 bit typed = 0, logic [7:0] want = '0);
        word_t w;
        w.fn = fn; w.ch = ch; w.addr = addr; w.len = len; w.lbeg = lbeg;
        w.lend = lend; w.lon = lon; w.per = per; w.data = data;
        w.typed = typed; w.want = want;
        return w;
    endfunction

    // fill any byte the next tick would read before it has been written
    task automatic issue(word_t w);
        logic [31:0] p;
        logic [15:0] a;
        if (w.fn == FUNC_TICK)
        begin
            for (int c = 0; c < 4; c++)
            begin
                p = pos[c];
                if (lp_on[c] && p > lp_end[c])
                    p = lp_beg[c];
                a = read_addr(c, p);
                if (playing[c] && p < span[c] && !mem_known[a])
                begin
                    word_t f;
                    f = mk(FUNC_WRITE, 2'($urandom), a, $urandom, $urandom, $urandom,
                           1'($urandom), 16'($urandom), 8'($urandom));
                    apply_word(f);
                    drive_word(f);
                end
            end
        end
        apply_word(w);
        drive_word(w);
    endtask

    task automatic write_rate(logic [31:0] v);
        cfg_data <= v;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        rate = v;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (mix_expected.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [31:0] pick_pos();
        return ($urandom_range(0, 1) == 0) ? $urandom_range(0, 32'h0040_0000) : $urandom;
    endfunction

    function automatic word_t random_word();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return mk(FUNC_TICK, 2'($urandom), 16'($urandom), $urandom, $urandom,
                      $urandom, 1'($urandom), 16'($urandom), 8'($urandom));
        if (r < 80)
            return mk(FUNC_START, 2'($urandom), 16'($urandom), pick_pos(), pick_pos(),
                      pick_pos(), 1'($urandom),
                      ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                  : 16'($urandom_range(0, 4)),
                      8'($urandom));
        if (r < 95)
            return mk(FUNC_WRITE, 2'($urandom), 16'($urandom), $urandom, $urandom,
                      $urandom, 1'($urandom), 16'($urandom), 8'($urandom));
        return mk(FUNC_NONE, 2'($urandom), 16'($urandom), $urandom, $urandom,
                  $urandom, 1'($urandom), 16'($urandom), 8'($urandom));
    endfunction

    always
    begin
        int g;
        if (hold_req)
        begin
            out_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clk);
            hold_req = 1'b0;
        end
        g = draw_gap();
        if (g > 0)
        begin
            out_ready <= 1'b0;
            repeat (g) @(posedge clk);
        end
        out_ready <= 1'b1;
        do @(posedge clk); while (!(out_valid && rst_n));
        if (mix_expected.size() == 0)
            report("unexpected word", mixed_sample, 0);
        else
        begin
            logic [7:0] e;
            e = mix_expected.pop_front();
            if (mixed_sample !== e)
                report("mixed_sample", mixed_sample, $signed(e));
        end
    end

    initial
    begin
        word_t rows [$];
        logic [31:0] rates [5];
        errors = 0;
        no_gaps = 0;
        hold_req = 0;
        rate = RATE_FACTOR_RESET;
        for (int c = 0; c < 4; c++)
        begin
            pos[c] = '0; base[c] = '0; span[c] = '0; lp_beg[c] = '0;
            lp_end[c] = '0; lp_on[c] = 0; step_div[c] = '0; playing[c] = 0;
        end
        for (int a = 0; a < 65536; a++)
        begin
            mem_byte[a] = '0;
            mem_known[a] = 0;
        end
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        in_valid = 1'b0;
        func = FUNC_TICK;
        channel = '0;
        sample_addr = '0;
        length = '0;
        loop_start = '0;
        loop_end = '0;
        loop_on = 1'b0;
        period = '0;
        sample_data = '0;
        out_ready = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        rows.push_back(mk(FUNC_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 1, 8'd0));
        rows.push_back(mk(FUNC_WRITE, 0, 16'h0000, 0, 0, 0, 0, 0, 8'h7F));
        rows.push_back(mk(FUNC_WRITE, 0, 16'hFFFF, 0, 0, 0, 0, 0, 8'h80));
        rows.push_back(mk(FUNC_WRITE, 0, 16'h0001, 0, 0, 0, 0, 0, 8'hFF));
        rows.push_back(mk(FUNC_WRITE, 0, 16'h0002, 0, 0, 0, 0, 0, 8'h40));
        rows.push_back(mk(FUNC_START, 0, 16'h0000, '1, 0, '1, 0, 0, 0));
        rows.push_back(mk(FUNC_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 1, 8'd31));
        rows.push_back(mk(FUNC_START, 1, 16'hFFFF, '1, 0, 0, 0, 0, 0));
        rows.push_back(mk(FUNC_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 1, 8'd0));
        rows.push_back(mk(FUNC_START, 1, 16'h0001, '1, 0, 0, 0, 0, 0));
        rows.push_back(mk(FUNC_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 1, 8'd31));
        rows.push_back(mk(FUNC_START, 2, 16'h0000, 0, 0, 0, 0, 0, 0));
        rows.push_back(mk(FUNC_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 1, 8'd31));
        rows.push_back(mk(FUNC_START, 3, 16'h0000, 32'h0003_0000, 32'h0001_0000,
                          32'h0000_8000, 1, 16'd1, 0));
        rows.push_back(mk(FUNC_TICK, 0, 0, 0, 0, 0, 0, 0, 0));
        rows.push_back(mk(FUNC_TICK, 0, 0, 0, 0, 0, 0, 0, 0));
        rows.push_back(mk(FUNC_NONE, '1, '1, '1, '1, '1, 1, '1, '1));
        rows.push_back(mk(FUNC_TICK, 0, 0, 0, 0, 0, 0, 0, 0));
        rows.push_back(mk(FUNC_START, 0, 16'hFFFF, 32'h0002_0000, '1, '1, 1, '1, 0));
        rows.push_back(mk(FUNC_TICK, 0, 0, 0, 0, 0, 0, 0, 0));
        rows.push_back(mk(FUNC_START, 2, 16'h8000, '1, 0, 0, 0, 16'd1, 0));
        rows.push_back(mk(FUNC_TICK, 0, 0, 0, 0, 0, 0, 0, 0));
        rows.push_back(mk(FUNC_TICK, 0, 0, 0, 0, 0, 0, 0, 0));
        rows.push_back(mk(FUNC_TICK, 0, 0, 0, 0, 0, 0, 0, 0));
        foreach (rows[i])
            issue(rows[i]);
        drain();

        rates[0] = 32'd0;
        rates[1] = 32'hFFFF_FFFF;
        rates[2] = $urandom;
        rates[3] = 32'd1;
        rates[4] = RATE_FACTOR_RESET;
        for (int ph = 0; ph < 5; ph++)
        begin
            write_rate(rates[ph]);
            no_gaps = (ph == 3);
            if (ph == 1)
                hold_req = 1'b1;
            for (int i = 0; i < 120; i++)
                issue(random_word());
            drain();
        end

        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
